@@ rtl/core/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants of the SHA-256 stream hasher
// Round constants, initial hash values, action codes and the state encoding
// of the byte and round sequencer.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned RoundCount = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos     = 56;

  typedef logic [1:0] action_t;
  localparam action_t ActAbsorb       = 2'd0;
  localparam action_t ActAbsorbFinish = 2'd1;
  localparam action_t ActFinish       = 2'd2;

  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [3:0] {
    StIdle,
    StWrite,
    StLoad,
    StRound,
    StFold,
    StPadFill,
    StPadLen,
    StEmit
  } state_e;

  // Request from the sequencer into the compression unit.
  typedef struct packed {
    logic start;
    logic init;
  } cmp_ctrl_t;

  typedef logic [255:0] chain_t;

  localparam chain_t InitHash = {
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hB5C0FBCF;
      6'd3: k = 32'hE9B5DBA5;  6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
      6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;  6'd8: k = 32'hD807AA98;
      6'd9: k = 32'h12835B01;  6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE; 6'd14: k = 32'h9BDC06A7;
      6'd15: k = 32'hC19BF174; 6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC; 6'd20: k = 32'h2DE92C6F;
      6'd21: k = 32'h4A7484AA; 6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D; 6'd26: k = 32'hB00327C8;
      6'd27: k = 32'hBF597FC7; 6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27B70A85;
      6'd33: k = 32'h2E1B2138; 6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB; 6'd38: k = 32'h81C2C92E;
      6'd39: k = 32'h92722C85; 6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3; 6'd44: k = 32'hD192E819;
      6'd45: k = 32'hD6990624; 6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08; 6'd50: k = 32'h2748774C;
      6'd51: k = 32'h34B0BCB5; 6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3; 6'd56: k = 32'h748F82EE;
      6'd57: k = 32'h78A5636F; 6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB; 6'd62: k = 32'hBEF9A3F7;
      default: k = 32'hC67178F2;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/sha_block_mem.sv @@
// ----------------------------------------------------------------------------
// sha_block_mem: message block buffer
// 16 x 32-bit synchronous memory with byte-lane writes and one registered
// read port. Holds the block in big-endian word order.
// ----------------------------------------------------------------------------
module sha_block_mem
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [3:0]  waddr_i,
  input  logic [3:0]  wbe_i,
  input  logic [31:0] wdata_i,
  input  logic [3:0]  raddr_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem [16];

  // Write enabled byte lanes
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < 4; b++) begin
        if (wbe_i[b]) begin
          mem[waddr_i][b*8 +: 8] <= wdata_i[b*8 +: 8];
        end
      end
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/sha_compress.sv @@
// ----------------------------------------------------------------------------
// sha_compress: SHA-256 round engine
// Takes one schedule word per cycle during the first 16 rounds, expands the
// rest in a 16-word window, runs one round per cycle and folds the working
// variables into the chain words at the end.
// ----------------------------------------------------------------------------
module sha_compress
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmp_ctrl_t   ctrl_i,
  input  logic [31:0] word_i,
  output logic [3:0]  raddr_o,
  output logic        busy_o,
  output chain_t      chain_o
);

  chain_t       chain_q, chain_d;
  logic [31:0]  var_q [8];
  logic [31:0]  var_d [8];
  logic [31:0]  win_q [16];
  logic [31:0]  win_d [16];
  logic [6:0]   cnt_q, cnt_d;
  logic         run_q, run_d;
  logic         fold_q, fold_d;

  logic [31:0] w, t1, t2, s0, s1, w15, w2, e, a;
  logic [5:0]  rnd;

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // The round counter catches up with the memory read address in the next cycle
  assign rnd     = cnt_q[5:0];
  assign raddr_o = run_q ? cnt_d[3:0] : 4'd0;
  assign busy_o  = run_q | fold_q | ctrl_i.start;
  assign chain_o = chain_q;

  always_comb begin
    w15 = win_q[1];
    w2  = win_q[14];
    s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
    s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
    w   = (rnd < 6'd16) ? word_i : (win_q[0] + s0 + win_q[9] + s1);
    e   = var_q[4];
    a   = var_q[0];
    t1  = var_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
        + ((e & var_q[5]) ^ (~e & var_q[6])) + round_k(rnd) + w;
    t2  = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
        + ((a & var_q[1]) ^ (a & var_q[2]) ^ (var_q[1] & var_q[2]));
  end

  // Sequence rounds and fold
  always_comb begin
    chain_d = chain_q;
    var_d   = var_q;
    win_d   = win_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    fold_d  = 1'b0;
    if (ctrl_i.init) begin
      chain_d = InitHash;
    end
    if (ctrl_i.start) begin
      run_d = 1'b1;
      cnt_d = 7'd0;
      for (int i = 0; i < 8; i++) var_d[i] = chain_q[(7-i)*32 +: 32];
    end else if (run_q) begin
      // word_i is valid in the cycle after its read address is presented
      cnt_d = cnt_q + 7'd1;
      for (int i = 0; i < 15; i++) win_d[i] = win_q[i+1];
      win_d[15] = w;
      var_d[7] = var_q[6]; var_d[6] = var_q[5]; var_d[5] = var_q[4];
      var_d[4] = var_q[3] + t1;
      var_d[3] = var_q[2]; var_d[2] = var_q[1]; var_d[1] = var_q[0];
      var_d[0] = t1 + t2;
      if (cnt_q == 7'(RoundCount - 1)) begin
        run_d  = 1'b0;
        fold_d = 1'b1;
      end
    end else if (fold_q) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[(7-i)*32 +: 32] = chain_q[(7-i)*32 +: 32] + var_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= InitHash;
      cnt_q   <= '0;
      run_q   <= 1'b0;
      fold_q  <= 1'b0;
    end else begin
      chain_q <= chain_d;
      cnt_q   <= cnt_d;
      run_q   <= run_d;
      fold_q  <= fold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    var_q <= var_d;
    win_q <= win_d;
  end

endmodule

@@ rtl/core/sha256_stream_hasher_core.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core: streaming SHA-256 engine
// Byte input channel, digest output channel of four 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word per item: an
//   action and a message byte. Absorb writes the byte into the block buffer
//   memory; the 64th byte of a block starts a compression.
//   Output channel (out_valid_o/out_ready_i) carries four digest words after
//   each finish, part_index 0..3, last_part on the fourth.
// Sequence:
//   A plain absorb that does not close a block goes straight back to idle.
//   A full block adds a read lead-in, 64 rounds, one fold and one check
//   that the round engine is done.
//   Finish pads in place: padding and length word writes, one or two
//   compressions, then four output words.
// Reset: chain words take the initial hash values, fill and bit counts clear;
//   the buffer memory is not cleared and needs no sweep.
// Stall: a held output word holds the block; no input is taken until the
//   last digest word leaves.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_part_o,
  output logic [1:0]  part_index_o,
  output logic        last_part_o
);

  state_e      state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] total_q, total_d;
  logic        fin_q, fin_d;       // finish pending after current compress
  logic        second_q, second_d; // length block or final compression still to go
  logic [3:0]  pw_q, pw_d;         // pad word pointer
  logic [1:0]  part_q, part_d;

  logic        we;
  logic [3:0]  waddr, wbe;
  logic [31:0] wdata;
  logic [3:0]  raddr;
  logic [31:0] rdata;
  cmp_ctrl_t   cctl;
  logic        busy;
  chain_t      chain;
  logic        acc;

  sha_block_mem u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wbe_i(wbe), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  sha_compress u_cmp (
    .clk_i, .rst_ni, .ctrl_i(cctl), .word_i(rdata), .raddr_o(raddr),
    .busy_o(busy), .chain_o(chain)
  );

  assign in_ready_o    = (state_q == StIdle);
  assign acc           = in_valid_i & in_ready_o;
  assign out_valid_o   = (state_q == StEmit) && !second_q;
  assign digest_part_o = chain[(3 - part_q)*64 +: 64];
  assign part_index_o  = part_q;
  assign last_part_o   = (part_q == 2'd3);

  // Next state, memory writes and compression requests
  always_comb begin
    logic [3:0] fw;
    logic [1:0] fb;
    state_d  = state_q;
    fill_d   = fill_q;
    bits_d   = bits_q;
    total_d  = total_q;
    fin_d    = fin_q;
    second_d = second_q;
    pw_d     = pw_q;
    part_d   = part_q;
    we       = 1'b0;
    waddr    = fill_q[5:2];
    wbe      = '0;
    wdata    = '0;
    cctl     = '0;
    fw       = fill_q[5:2];
    fb       = fill_q[1:0];
    case (state_q)
      StIdle: begin
        if (acc) begin
          if (action_i == ActAbsorb || action_i == ActAbsorbFinish) begin
            we    = 1'b1;
            wbe   = 4'b1000 >> fb;
            wdata = {4{data_byte_i}};
            fin_d = (action_i == ActAbsorbFinish);
            if (fill_q == 6'(BlockBytes - 1)) begin
              fill_d  = '0;
              bits_d  = bits_q + 64'd512;
              state_d = StLoad;
            end else begin
              fill_d  = fill_q + 6'd1;
              state_d = fin_d ? StPadFill : StIdle;
              pw_d    = fill_d[5:2];
            end
          end else if (action_i == ActFinish) begin
            fin_d   = 1'b1;
            state_d = StPadFill;
            pw_d    = fw;
          end
        end
      end
      StLoad: begin
        cctl.start = 1'b1;
        state_d    = StRound;
      end
      StRound: begin
        if (!busy) begin
          if (second_q) begin
            second_d = 1'b0;
            pw_d     = '0;
            state_d  = StPadLen;
          end else if (fin_q) begin
            pw_d    = '0;
            state_d = StPadFill;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StPadFill: begin
        // First pass: 0x80 at fill, zero the rest of the word then later ones
        if (pw_q == fw) begin
          total_d = bits_q + {55'd0, fill_q, 3'd0};
        end
        we    = 1'b1;
        waddr = pw_q;
        if (pw_q == fw) begin
          wbe   = 4'b1111 >> fb;
          wdata = {PadByte, 24'd0} >> {fb, 3'd0};
        end else begin
          wbe   = 4'b1111;
          wdata = '0;
        end
        if (pw_q == 4'd15) begin
          if (fill_q >= 6'(LenPos)) begin
            second_d = 1'b1;
            fin_d    = 1'b0;
            fill_d   = '0;
            state_d  = StLoad;
          end else begin
            we      = 1'b1;
            state_d = StPadLen;
            pw_d    = 4'd14;
          end
        end else begin
          pw_d = pw_q + 4'd1;
        end
        if (pw_q == 4'd15 && fill_q < 6'(LenPos)) begin
          wbe = (pw_q == fw) ? (4'b1111 >> fb) : 4'b1111;
        end
      end
      StPadLen: begin
        // Length words; a fresh length block needs all 16 words zeroed
        we    = 1'b1;
        waddr = pw_q;
        wbe   = 4'b1111;
        if (pw_q == 4'd14) wdata = total_q[63:32];
        else if (pw_q == 4'd15) wdata = total_q[31:0];
        else wdata = '0;
        if (pw_q == 4'd15) begin
          fin_d   = 1'b0;
          fill_d  = '0;
          bits_d  = '0;
          part_d  = '0;
          state_d = StFold;
        end else begin
          pw_d = pw_q + 4'd1;
        end
      end
      StFold: begin
        cctl.start = 1'b1;
        state_d    = StEmit;
        second_d   = 1'b1;
      end
      StEmit: begin
        if (second_q && busy) begin
          state_d = StEmit;
        end
        if (second_q) begin
          // wait for final compression before presenting the digest
          if (!busy) second_d = 1'b0;
        end else if (out_ready_i) begin
          part_d = part_q + 2'd1;
          if (part_q == 2'd3) begin
            cctl.init = 1'b1;
            state_d   = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      bits_q   <= '0;
      fin_q    <= 1'b0;
      second_q <= 1'b0;
      pw_q     <= '0;
      part_q   <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      bits_q   <= bits_d;
      fin_q    <= fin_d;
      second_q <= second_d;
      pw_q     <= pw_d;
      part_q   <= part_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o) else $error("input taken during compression");
  a_part_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_part_o) |=> in_ready_o)
    else $error("block did not return to idle after digest");
  a_fill_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_part_o) |=> (fill_q == 6'd0))
    else $error("fill count not cleared after finish");
`endif

endmodule
